// ===== rtl/svpwm_pkg.sv =====
// shared types and constants for the svpwm single-shunt compare core
`default_nettype none
package svpwm_pkg;

  // fixed coefficient of the reference projections
  localparam logic signed [17:0] K_COS30 = 18'sd28376;

  // divider sizes
  localparam int unsigned DIV_W = 32;
  localparam int unsigned DVS_W = 17;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_PWM_PERIOD  = 3'd0,
    CFG_SQRT3_GAIN  = 3'd1,
    CFG_STABLE_WIN  = 3'd2,
    CFG_SAMPLE_SHFT = 3'd3,
    CFG_PS_ENABLE   = 3'd4
  } cfg_idx_t;

  // multiplier operations
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_GAIN,
    MUL_A,
    MUL_X,
    MUL_Y,
    MUL_Z,
    MUL_T1P,
    MUL_T2P
  } mul_op_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load_in;
    mul_op_t mul_op;
    logic    div_start;
    logic    div_gain;
    logic    cap_coeff;
    logic    cap_t1q;
    logic    cap_t2q;
    logic    cap_sec;
    logic    cap_times;
    logic    load_out;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic scale;
    logic out_free;
  } dp_stat_t;

  // phase slots of the lowest, middle and highest edge
  typedef struct packed {
    logic [1:0] lo;
    logic [1:0] mid;
    logic [1:0] hi;
  } slots_t;

  function automatic slots_t sector_slots(input logic [2:0] sec);
    slots_t r;
    unique case (sec)
      3'd0:    r = '{lo: 2'd0, mid: 2'd1, hi: 2'd2};
      3'd1:    r = '{lo: 2'd1, mid: 2'd0, hi: 2'd2};
      3'd2:    r = '{lo: 2'd1, mid: 2'd2, hi: 2'd0};
      3'd3:    r = '{lo: 2'd2, mid: 2'd1, hi: 2'd0};
      3'd4:    r = '{lo: 2'd2, mid: 2'd0, hi: 2'd1};
      3'd5:    r = '{lo: 2'd0, mid: 2'd2, hi: 2'd1};
      default: r = '{lo: 2'd0, mid: 2'd1, hi: 2'd2};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/svpwm_div.sv =====
// restoring serial divider, one quotient bit per cycle
`default_nettype none
module svpwm_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [svpwm_pkg::DIV_W-1:0]    dividend,
  input  wire logic [svpwm_pkg::DVS_W-1:0]    divisor,
  output logic      [svpwm_pkg::DIV_W-1:0]    quotient,
  output logic                                done
);

  localparam int unsigned CW = $clog2(svpwm_pkg::DIV_W);

  logic                          busy;
  logic [CW-1:0]                 cnt;
  logic [svpwm_pkg::DVS_W-1:0]   rem;
  logic [svpwm_pkg::DVS_W-1:0]   dvs;
  logic [svpwm_pkg::DVS_W:0]     rem_sh;
  logic [svpwm_pkg::DVS_W:0]     diff;
  logic                          ge;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem, quotient[svpwm_pkg::DIV_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = (rem_sh >= {1'b0, dvs});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(svpwm_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= ge ? diff[svpwm_pkg::DVS_W-1:0] : rem_sh[svpwm_pkg::DVS_W-1:0];
      quotient <= {quotient[svpwm_pkg::DIV_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/svpwm_dp.sv =====
// datapath: config registers, shared multiplier, divider and compare placement
`default_nettype none
module svpwm_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire svpwm_pkg::dp_cmd_t cmd,
  output svpwm_pkg::dp_stat_t     stat,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic signed [15:0] alpha_volt,
  input  wire logic signed [15:0] beta_volt,
  input  wire logic [14:0]        bus_volt,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              sector,
  output logic signed [16:0]      cmp_a_up,
  output logic signed [16:0]      cmp_b_up,
  output logic signed [16:0]      cmp_c_up,
  output logic signed [16:0]      cmp_a_down,
  output logic signed [16:0]      cmp_b_down,
  output logic signed [16:0]      cmp_c_down,
  output logic [15:0]             sample_point_one,
  output logic [15:0]             sample_point_two
);

  // configuration
  logic [14:0] pwm_period;
  logic [15:0] sqrt3_gain;
  logic [14:0] stable_window;
  logic [14:0] sample_shift;
  logic        phase_shift_enable;

  // captured transaction
  logic signed [15:0] re;
  logic signed [15:0] im;
  logic [14:0]        bus;

  // intermediate values
  logic [30:0]        gprod;
  logic [14:0]        coeff;
  logic signed [31:0] a_reg;
  logic signed [17:0] cy, cz, x, y, z;
  logic [2:0]         n;
  logic [2:0]         last_sector;
  logic [2:0]         sec;
  logic signed [17:0] t1s, t2s, half;
  logic               scale;
  logic               tp_neg;
  logic [31:0]        tp_mag;
  logic signed [33:0] t1w, t2w;
  logic [14:0]        t0, t1, t2;

  // multiplier
  logic signed [17:0] ma, mb;
  logic signed [35:0] prod;
  logic signed [35:0] prod_abs;

  // divider
  logic [31:0] div_q;
  logic        div_done;
  logic [31:0] dvd;
  logic [16:0] dvs;

  // combinational helpers
  logic signed [32:0] a33, h33, sum_y, dif_z, d2, d3;
  logic               v2pos, v3pos;
  logic signed [17:0] t1_sel, t2_sel;
  logic [2:0]         sec_sel;
  logic signed [18:0] tsum;
  logic signed [35:0] t1h, t2h, t0d, t0e;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period         <= 15'd3000;
      sqrt3_gain         <= 16'd56756;
      stable_window      <= 15'd200;
      sample_shift       <= 15'd100;
      phase_shift_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        svpwm_pkg::CFG_PWM_PERIOD:  pwm_period         <= cfg_data[14:0];
        svpwm_pkg::CFG_SQRT3_GAIN:  sqrt3_gain         <= cfg_data;
        svpwm_pkg::CFG_STABLE_WIN:  stable_window      <= cfg_data[14:0];
        svpwm_pkg::CFG_SAMPLE_SHFT: sample_shift       <= cfg_data[14:0];
        svpwm_pkg::CFG_PS_ENABLE:   phase_shift_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    unique case (cmd.mul_op)
      svpwm_pkg::MUL_GAIN: begin ma = {3'b0, pwm_period}; mb = {2'b0, sqrt3_gain}; end
      svpwm_pkg::MUL_A:    begin ma = svpwm_pkg::K_COS30; mb = {{2{re[15]}}, re}; end
      svpwm_pkg::MUL_X:    begin ma = {3'b0, coeff}; mb = {{2{im[15]}}, im}; end
      svpwm_pkg::MUL_Y:    begin ma = {3'b0, coeff}; mb = cy; end
      svpwm_pkg::MUL_Z:    begin ma = {3'b0, coeff}; mb = cz; end
      svpwm_pkg::MUL_T1P:  begin ma = t1s; mb = {3'b0, pwm_period}; end
      svpwm_pkg::MUL_T2P:  begin ma = t2s; mb = {3'b0, pwm_period}; end
      default:             begin ma = '0; mb = '0; end
    endcase
    prod     = ma * mb;
    prod_abs = prod[35] ? -prod : prod;
  end

  // projections from the cos30 product
  always_comb begin
    a33   = {a_reg[31], a_reg};
    h33   = {{3{im[15]}}, im, 14'b0};
    sum_y = a33 + h33;
    dif_z = h33 - a33;
    d2    = a33 - h33;
    d3    = -a33 - h33;
    v2pos = !d2[32] && (d2[31:15] != '0);
    v3pos = !d3[32] && (d3[31:15] != '0);
  end

  // sector decode and active time selection
  always_comb begin
    sec_sel = last_sector;
    t1_sel  = '0;
    t2_sel  = '0;
    unique case (n)
      3'd1:    begin t1_sel = z;  t2_sel = y;  sec_sel = 3'd1; end
      3'd2:    begin t1_sel = y;  t2_sel = -x; sec_sel = 3'd5; end
      3'd3:    begin t1_sel = -z; t2_sel = x;  sec_sel = 3'd0; end
      3'd4:    begin t1_sel = -x; t2_sel = z;  sec_sel = 3'd3; end
      3'd5:    begin t1_sel = x;  t2_sel = -y; sec_sel = 3'd2; end
      3'd6:    begin t1_sel = -y; t2_sel = -z; sec_sel = 3'd4; end
      default: ;
    endcase
    if (sec_sel > 3'd5) sec_sel = 3'd0;
    tsum = {t1_sel[17], t1_sel} + {t2_sel[17], t2_sel};
  end

  // divider operands
  always_comb begin
    dvd = cmd.div_gain ? {gprod[30:14], 15'b0} : tp_mag;
    dvs = cmd.div_gain ? {2'b0, bus} : half[16:0];
  end

  svpwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  // halving and zero time
  always_comb begin
    t1h = {{3{t1w[33]}}, t1w[33:1]};
    t2h = {{3{t2w[33]}}, t2w[33:1]};
    t0d = {21'b0, pwm_period} - t1h - t2h;
    t0e = {t0d[35], t0d[35:1]};
  end

  function automatic logic [14:0] sat_p(input logic signed [35:0] v, input logic [14:0] p);
    logic [14:0] r;
    if (v[35])                           r = '0;
    else if (v[34:0] > {20'b0, p})       r = p;
    else                                 r = v[14:0];
    return r;
  endfunction

  // captures driven by the controller
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sector <= '0;
    end else if (cmd.cap_sec) begin
      last_sector <= sec_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      re  <= alpha_volt;
      im  <= beta_volt;
      bus <= bus_volt;
    end
    unique case (cmd.mul_op)
      svpwm_pkg::MUL_GAIN: gprod <= prod[30:0];
      svpwm_pkg::MUL_A:    a_reg <= prod[31:0];
      svpwm_pkg::MUL_X: begin
        x  <= prod[32:15];
        cy <= sum_y[32:15];
        cz <= dif_z[32:15];
        n  <= {v3pos, v2pos, im > 16'sd0};
      end
      svpwm_pkg::MUL_Y:    y <= prod[32:15];
      svpwm_pkg::MUL_Z:    z <= prod[32:15];
      svpwm_pkg::MUL_T1P,
      svpwm_pkg::MUL_T2P: begin
        tp_neg <= prod[35];
        tp_mag <= prod_abs[31:0];
      end
      default: ;
    endcase
    if (cmd.cap_coeff) coeff <= (div_q[31:15] != '0) ? 15'h7fff : div_q[14:0];
    if (cmd.cap_sec) begin
      sec   <= sec_sel;
      t1s   <= t1_sel;
      t2s   <= t2_sel;
      half  <= tsum[18:1];
      scale <= ($signed(tsum[18:1]) > $signed({3'b0, pwm_period}));
      t1w   <= {{16{t1_sel[17]}}, t1_sel};
      t2w   <= {{16{t2_sel[17]}}, t2_sel};
    end
    if (cmd.cap_t1q) t1w <= tp_neg ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});
    if (cmd.cap_t2q) t2w <= tp_neg ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});
    if (cmd.cap_times) begin
      t0 <= sat_p(t0e, pwm_period);
      t1 <= sat_p({{2{t1h[33]}}, t1h[33:0]}, pwm_period);
      t2 <= sat_p({{2{t2h[33]}}, t2h[33:0]}, pwm_period);
    end
  end

  // edge placement and phase shifting
  logic signed [18:0] w0, w1, w2, ws, wp, ta, tb, tc;
  logic signed [18:0] u_lo, d_lo, u_mid, d_mid, u_hi, d_hi;
  logic signed [18:0] up_k [3];
  logic signed [18:0] dn_k [3];
  svpwm_pkg::slots_t  sl;

  always_comb begin
    w0 = {4'b0, t0};
    w1 = {4'b0, t1};
    w2 = {4'b0, t2};
    ws = {4'b0, stable_window};
    wp = {4'b0, pwm_period};
    ta = w0;
    tb = w0 + w1;
    tc = tb + w2;
    u_lo = ta; d_lo = ta; u_mid = tb; d_mid = tb; u_hi = tc; d_hi = tc;
    if (phase_shift_enable) begin
      priority if (w1 < ws && w2 < ws) begin
        u_lo = ta - (ws - w1);
        d_lo = ta + (ws - w1);
        if (u_lo < 19'sd0) u_lo = '0;
        u_hi = tc + (ws - w2);
        d_hi = tc - (ws - w2);
      end else if (w1 < ws && w2 > ws) begin
        if (w1 + w0 > ws) begin
          u_lo = ta - (ws - w1);
          d_lo = ta + (ws - w1);
        end else begin
          u_lo = '0;
          d_lo = ta + w0;
          if (w0 + w1 + w2 >= (ws <<< 1)) begin
            u_mid = tb + (ws - (w1 + w0));
            d_mid = tb - (ws - (w1 + w0));
          end
        end
      end else if (w1 > ws && w2 < ws) begin
        if (w2 + w0 > ws) begin
          u_hi = tc + (ws - w2);
          d_hi = tc - (ws - w2);
        end else begin
          u_hi = wp;
          d_hi = tc - w0;
          if (w0 + w1 + w2 >= (ws <<< 1)) begin
            u_mid = tb - (ws - (w2 + w0));
            d_mid = tb + (ws - (w2 + w0));
          end
        end
      end else begin
      end
    end
    sl = svpwm_pkg::sector_slots(sec);
    for (int k = 0; k < 3; k++) begin
      if (sl.lo == 2'(k)) begin
        up_k[k] = u_lo;  dn_k[k] = d_lo;
      end else if (sl.mid == 2'(k)) begin
        up_k[k] = u_mid; dn_k[k] = d_mid;
      end else begin
        up_k[k] = u_hi;  dn_k[k] = d_hi;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sector           <= sec;
      cmp_a_up         <= up_k[0][16:0];
      cmp_b_up         <= up_k[1][16:0];
      cmp_c_up         <= up_k[2][16:0];
      cmp_a_down       <= dn_k[0][16:0];
      cmp_b_down       <= dn_k[1][16:0];
      cmp_c_down       <= dn_k[2][16:0];
      sample_point_one <= u_lo[15:0] + {1'b0, sample_shift};
      sample_point_two <= u_mid[15:0] + {1'b0, sample_shift};
    end
  end

  assign stat.div_done = div_done;
  assign stat.scale    = scale;
  assign stat.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== rtl/svpwm_ctrl.sv =====
// controller: sequences the multiplier, divider and captures for one transaction
`default_nettype none
module svpwm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output svpwm_pkg::dp_cmd_t       cmd,
  input  wire svpwm_pkg::dp_stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE, S_MG, S_GDS, S_GDW, S_MA, S_MX, S_MY, S_MZ, S_SEC, S_CHK,
    S_MP1, S_D1S, S_D1W, S_MP2, S_D2S, S_D2W, S_TIMES, S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_op = svpwm_pkg::MUL_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MG;
        end
      end
      S_MG:  begin cmd.mul_op = svpwm_pkg::MUL_GAIN; state_next = S_GDS; end
      S_GDS: begin cmd.div_start = 1'b1; cmd.div_gain = 1'b1; state_next = S_GDW; end
      S_GDW: begin
        cmd.div_gain = 1'b1;
        if (stat.div_done) begin
          cmd.cap_coeff = 1'b1;
          state_next    = S_MA;
        end
      end
      S_MA:  begin cmd.mul_op = svpwm_pkg::MUL_A; state_next = S_MX; end
      S_MX:  begin cmd.mul_op = svpwm_pkg::MUL_X; state_next = S_MY; end
      S_MY:  begin cmd.mul_op = svpwm_pkg::MUL_Y; state_next = S_MZ; end
      S_MZ:  begin cmd.mul_op = svpwm_pkg::MUL_Z; state_next = S_SEC; end
      S_SEC: begin cmd.cap_sec = 1'b1; state_next = S_CHK; end
      S_CHK: state_next = stat.scale ? S_MP1 : S_TIMES;
      S_MP1: begin cmd.mul_op = svpwm_pkg::MUL_T1P; state_next = S_D1S; end
      S_D1S: begin cmd.div_start = 1'b1; state_next = S_D1W; end
      S_D1W: begin
        if (stat.div_done) begin
          cmd.cap_t1q = 1'b1;
          state_next  = S_MP2;
        end
      end
      S_MP2: begin cmd.mul_op = svpwm_pkg::MUL_T2P; state_next = S_D2S; end
      S_D2S: begin cmd.div_start = 1'b1; state_next = S_D2W; end
      S_D2W: begin
        if (stat.div_done) begin
          cmd.cap_t2q = 1'b1;
          state_next  = S_TIMES;
        end
      end
      S_TIMES: begin cmd.cap_times = 1'b1; state_next = S_OUT; end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/svpwm_single_shunt_compare_core.sv =====
// Space-vector PWM compare core with single-shunt phase shifting.
// Input channel (in_valid/in_ready) takes one alpha/beta voltage command and
// a bus voltage sample per transaction; output channel (out_valid/out_ready)
// returns the sector, six compare values and two ADC sample points.
// The block works on one transaction at a time and takes the next one only
// once the result of the last has been loaded into the output register;
// the latency is longer when the active times exceed the period.
// The run time is set by the one-bit-per-cycle divider (used for the gain
// and, when scaling, for each active time) and the shared multiplier,
// which does five products in sequence, seven when scaling.
// A finished result sits in an output register, so the next transaction is
// accepted while it waits; if the receiver stalls, the next result waits in
// the controller until the register frees.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
// clock edge and should only be made while the block is idle.
// Synchronous reset loads the register defaults, clears the remembered
// sector and empties the output register.
`default_nettype none
module svpwm_single_shunt_compare_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] alpha_volt,
  input  wire logic signed [15:0] beta_volt,
  input  wire logic [14:0]        bus_volt,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              sector,
  output logic signed [16:0]      cmp_a_up,
  output logic signed [16:0]      cmp_b_up,
  output logic signed [16:0]      cmp_c_up,
  output logic signed [16:0]      cmp_a_down,
  output logic signed [16:0]      cmp_b_down,
  output logic signed [16:0]      cmp_c_down,
  output logic [15:0]             sample_point_one,
  output logic [15:0]             sample_point_two
);

  svpwm_pkg::dp_cmd_t  cmd;
  svpwm_pkg::dp_stat_t stat;

  // sequencing
  svpwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // arithmetic
  svpwm_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .alpha_volt       (alpha_volt),
    .beta_volt        (beta_volt),
    .bus_volt         (bus_volt),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .sector           (sector),
    .cmp_a_up         (cmp_a_up),
    .cmp_b_up         (cmp_b_up),
    .cmp_c_up         (cmp_c_up),
    .cmp_a_down       (cmp_a_down),
    .cmp_b_down       (cmp_b_down),
    .cmp_c_down       (cmp_c_down),
    .sample_point_one (sample_point_one),
    .sample_point_two (sample_point_two)
  );

endmodule
`default_nettype wire

// ===== rtl/svpwm_checker.sv =====
// port-level checks for the svpwm compare core, bound to the top level
`default_nettype none
module svpwm_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [2:0]         sector,
  input wire logic signed [16:0] cmp_a_up
);

  // a stalled result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sector) && $stable(cmp_a_up))
    else $error("result dropped or changed under stall");

  // sector code is always a real sector
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sector <= 3'd5)
    else $error("sector out of range");

  // after a transaction is taken the block is busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind svpwm_single_shunt_compare_core svpwm_checker u_svpwm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .sector    (sector),
  .cmp_a_up  (cmp_a_up)
);
`default_nettype wire

// ===== verif/tb_svpwm_single_shunt_compare_core.sv =====
// testbench for the svpwm single-shunt compare core: self-checking, random bursts and stalls
`default_nettype none
module tb_svpwm_single_shunt_compare_core;

  localparam int CLK_HALF = 6;
  localparam int SETTLE_CYCLES = 150;
  localparam logic [2:0] CFG_UNMAPPED = 3'd7;
  localparam longint COS30_Q15 = 28376;
  localparam longint HALF_Q15 = 16384;

  // one expected result transaction
  typedef struct {
    logic [2:0]  sector;
    logic [16:0] cmp [6];
    logic [15:0] spt_one;
    logic [15:0] spt_two;
  } compare_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] alpha_volt = '0;
  logic signed [15:0] beta_volt = '0;
  logic [14:0] bus_volt = 15'd1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] sector;
  logic signed [16:0] cmp_a_up, cmp_b_up, cmp_c_up;
  logic signed [16:0] cmp_a_down, cmp_b_down, cmp_c_down;
  logic [15:0] sample_point_one, sample_point_two;

  // shadow of the block's registers and remembered sector
  longint period_q, gain_q, window_q, shift_q;
  bit shift_en_q;
  logic [2:0] held_sector;

  compare_set_t expected_q[$];
  int error_count = 0;
  int burst_left = 0;
  int hold_requests = 0;
  int hold_served = 0;

  svpwm_single_shunt_compare_core u_dut (.*);

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // edge order of the lowest, middle and highest compare per sector
  function automatic int edge_slot(int which, logic [2:0] sec);
    int lo_tab [6] = '{0, 1, 1, 2, 2, 0};
    int mid_tab [6] = '{1, 0, 2, 1, 0, 2};
    int hi_tab [6] = '{2, 2, 0, 0, 1, 1};
    if (which == 0) return lo_tab[sec];
    if (which == 1) return mid_tab[sec];
    return hi_tab[sec];
  endfunction

  // compare values for one voltage command, advances the remembered sector
  function automatic compare_set_t predict_compares(logic signed [15:0] a,
                                                    logic signed [15:0] b,
                                                    logic [14:0] bus);
    compare_set_t r;
    longint re, im, p, s, g, coeff, x, y, z, v2, v3, t0, t1, t2, half;
    longint up [3];
    longint dn [3];
    int n, lo, mid, hi;
    logic [2:0] sec;
    re = a;
    im = b;
    p = period_q;
    s = window_q;
    g = ((2 * p * gain_q) >> 15) << 15;
    coeff = (bus == 0) ? 32767 : g / longint'(bus);
    if (coeff > 32767) coeff = 32767;
    x = (coeff * im) >>> 15;
    y = (coeff * ((COS30_Q15 * re + HALF_Q15 * im) >>> 15)) >>> 15;
    z = (coeff * ((HALF_Q15 * im - COS30_Q15 * re) >>> 15)) >>> 15;
    v2 = (COS30_Q15 * re - HALF_Q15 * im) >>> 15;
    v3 = (-COS30_Q15 * re - HALF_Q15 * im) >>> 15;
    n = 4 * (v3 > 0) + 2 * (v2 > 0) + (im > 0);
    // sector decode; zero vector keeps the previous sector
    sec = held_sector;
    t1 = 0;
    t2 = 0;
    case (n)
      1: begin t1 = z;  t2 = y;  sec = 3'd1; end
      2: begin t1 = y;  t2 = -x; sec = 3'd5; end
      3: begin t1 = -z; t2 = x;  sec = 3'd0; end
      4: begin t1 = -x; t2 = z;  sec = 3'd3; end
      5: begin t1 = x;  t2 = -y; sec = 3'd2; end
      6: begin t1 = -y; t2 = -z; sec = 3'd4; end
      default: ;
    endcase
    if (sec > 3'd5) sec = 3'd0;
    held_sector = sec;
    // overmodulation scaling, halving and saturation
    half = (t1 + t2) >>> 1;
    if (half > p) begin
      t1 = t1 * p / half;
      t2 = t2 * p / half;
    end
    t1 = t1 >>> 1;
    t2 = t2 >>> 1;
    t0 = (p - t1 - t2) >>> 1;
    t0 = (t0 < 0) ? 0 : ((t0 > p) ? p : t0);
    t1 = (t1 < 0) ? 0 : ((t1 > p) ? p : t1);
    t2 = (t2 < 0) ? 0 : ((t2 > p) ? p : t2);
    lo = edge_slot(0, sec);
    mid = edge_slot(1, sec);
    hi = edge_slot(2, sec);
    up[lo] = t0;
    up[mid] = t0 + t1;
    up[hi] = t0 + t1 + t2;
    for (int k = 0; k < 3; k++) dn[k] = up[k];
    // single-shunt stretching of short active vectors
    if (shift_en_q) begin
      if (t1 < s && t2 < s) begin
        up[lo] -= s - t1;
        dn[lo] += s - t1;
        if (up[lo] < 0) up[lo] = 0;
        up[hi] += s - t2;
        dn[hi] -= s - t2;
      end else if (t1 < s && t2 > s) begin
        if (t1 + t0 > s) begin
          up[lo] -= s - t1;
          dn[lo] += s - t1;
        end else begin
          up[lo] = 0;
          dn[lo] += t0;
          if (t0 + t1 + t2 >= 2 * s) begin
            up[mid] += s - (t1 + t0);
            dn[mid] -= s - (t1 + t0);
          end
        end
      end else if (t1 > s && t2 < s) begin
        if (t2 + t0 > s) begin
          up[hi] += s - t2;
          dn[hi] -= s - t2;
        end else begin
          up[hi] = p;
          dn[hi] -= t0;
          if (t0 + t1 + t2 >= 2 * s) begin
            up[mid] -= s - (t2 + t0);
            dn[mid] += s - (t2 + t0);
          end
        end
      end
    end
    r.sector = sec;
    for (int k = 0; k < 3; k++) begin
      r.cmp[k] = up[k][16:0];
      r.cmp[3 + k] = dn[k][16:0];
    end
    r.spt_one = 16'(up[lo] + shift_q);
    r.spt_two = 16'(up[mid] + shift_q);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // prediction on every accepted input transaction
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      expected_q.push_back(predict_compares(alpha_volt, beta_volt, bus_volt));
  end

  // receiver: stall pattern of its own plus long hold-offs on request
  always @(posedge clk) begin
    static int rx_mode = 0;
    static int rx_left = 0;
    static int hold_left = 0;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_left == 0 && hold_served < hold_requests) begin
        hold_served++;
        hold_left = 400;
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 300);
      end
      rx_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    compare_set_t want;
    logic [16:0] got_cmp [6];
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result transaction, sector", sector, -1);
      end else begin
        want = expected_q.pop_front();
        got_cmp = '{cmp_a_up, cmp_b_up, cmp_c_up, cmp_a_down, cmp_b_down, cmp_c_down};
        if (sector !== want.sector) report_mismatch("sector", sector, want.sector);
        for (int k = 0; k < 6; k++)
          if (got_cmp[k] !== want.cmp[k])
            report_mismatch($sformatf("compare %0d", k),
                            $signed(got_cmp[k]), $signed(want.cmp[k]));
        if (sample_point_one !== want.spt_one)
          report_mismatch("sample point one", sample_point_one, want.spt_one);
        if (sample_point_two !== want.spt_two)
          report_mismatch("sample point two", sample_point_two, want.spt_two);
      end
    end
  end

  // one input transaction, sent in bursts with random gaps
  task automatic send_item(logic signed [15:0] a, logic signed [15:0] b, logic [14:0] bus);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    alpha_volt <= a;
    beta_volt <= b;
    bus_volt <= bus;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      svpwm_pkg::CFG_PWM_PERIOD:  period_q = data[14:0];
      svpwm_pkg::CFG_SQRT3_GAIN:  gain_q = data;
      svpwm_pkg::CFG_STABLE_WIN:  window_q = data[14:0];
      svpwm_pkg::CFG_SAMPLE_SHFT: shift_q = data[14:0];
      svpwm_pkg::CFG_PS_ENABLE:   shift_en_q = data[0];
      default: ;
    endcase
  endtask

  task automatic write_all(int per, int gain, int win, int shft, int en);
    write_reg(svpwm_pkg::CFG_PWM_PERIOD, 16'(per));
    write_reg(svpwm_pkg::CFG_SQRT3_GAIN, 16'(gain));
    write_reg(svpwm_pkg::CFG_STABLE_WIN, 16'(win));
    write_reg(svpwm_pkg::CFG_SAMPLE_SHFT, 16'(shft));
    write_reg(svpwm_pkg::CFG_PS_ENABLE, 16'(en));
  endtask

  // random command: mostly full range, some short vectors and zero vectors
  task automatic send_random();
    int kind;
    logic signed [15:0] a, b;
    logic [14:0] bus;
    kind = $urandom_range(0, 9);
    a = 16'($urandom);
    b = 16'($urandom);
    if (kind < 2) begin
      a = $signed(16'($urandom_range(0, 1000))) - 16'sd500;
      b = $signed(16'($urandom_range(0, 1000))) - 16'sd500;
    end else if (kind == 2) begin
      a = '0;
      b = '0;
    end
    case ($urandom_range(0, 7))
      0: bus = 15'($urandom_range(0, 200));
      1: bus = 15'h7fff;
      default: bus = 15'($urandom_range(1000, 32767));
    endcase
    send_item(a, b, bus);
  endtask

  // extremes, zero vector, bus corners and each sector
  task automatic test_directed();
    send_item(16'sd0, 16'sd0, 15'd1000);
    send_item(16'sd32767, 16'sd32767, 15'd32767);
    send_item(-16'sd32768, -16'sd32768, 15'd32767);
    send_item(16'sd32767, -16'sd32768, 15'd1);
    send_item(-16'sd32768, 16'sd32767, 15'd0);
    send_item(16'sd0, 16'sd0, 15'd0);
    for (int k = 0; k < 6; k++) begin
      // one command near the middle of each sector
      send_item(16'(int'(8000.0 * $cos(3.14159 * (2 * k + 1) / 6.0))),
                16'(int'(8000.0 * $sin(3.14159 * (2 * k + 1) / 6.0))), 15'd20000);
      send_item(16'(int'(30000.0 * $cos(3.14159 * k / 3.0 + 0.2))),
                16'(int'(30000.0 * $sin(3.14159 * k / 3.0 + 0.2))), 15'd2000);
    end
    send_item(16'sd100, 16'sd20, 15'd20000);
    send_item(16'sd6000, 16'sd100, 15'd20000);
    send_item(-16'sd6000, 16'sd100, 15'd20000);
    send_item(16'sd10, 16'sd0, 15'd20000);
    send_item(16'sd0, -16'sd10, 15'd20000);
    wait_idle();
  endtask

  task automatic test_random(int count);
    repeat (count) send_random();
    wait_idle();
  endtask

  // register settings including every extreme
  task automatic test_config_sweep();
    write_reg(CFG_UNMAPPED, 16'hffff);
    write_all(1, 0, 0, 0, 0);
    test_random(60);
    write_all(32767, 65535, 32767, 32767, 1);
    test_random(60);
    write_all(3000, 56756, 0, 32767, 1);
    test_random(80);
    write_all(1500, 56756, 32767, 0, 1);
    test_random(60);
    write_all(3000, 56756, 200, 100, 0);
    test_random(80);
    write_all(2000, 65535, 500, 50, 1);
    test_random(100);
    repeat (3) begin
      write_all($urandom_range(1, 32767), $urandom_range(0, 65535),
                $urandom_range(0, 2000), $urandom_range(0, 32767), $urandom_range(0, 1));
      test_random(60);
    end
    write_all(3000, 56756, 200, 100, 1);
  endtask

  // long receiver hold-off while commands keep coming
  task automatic test_backpressure();
    hold_requests++;
    repeat (40) send_random();
    wait_idle();
  endtask

  initial begin
    period_q = 3000;
    gain_q = 56756;
    window_q = 200;
    shift_q = 100;
    shift_en_q = 1'b1;
    held_sector = 3'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(250);
    test_backpressure();
    test_config_sweep();
    test_backpressure();
    test_random(120);
    if (error_count == 0) begin
      $display("tb_svpwm_single_shunt_compare_core OK");
    end else begin
      $display("tb_svpwm_single_shunt_compare_core NOT OK");
    end
    $finish;
  end

  // run time limit
  initial begin
    #(2 * CLK_HALF * 4000000);
    $display("tb_svpwm_single_shunt_compare_core NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/svpwm_pkg.sv
rtl/svpwm_div.sv
rtl/svpwm_dp.sv
rtl/svpwm_ctrl.sv
rtl/svpwm_single_shunt_compare_core.sv
rtl/svpwm_checker.sv
verif/tb_svpwm_single_shunt_compare_core.sv
